/* hdl/huffman_table_encoder_packer_core_assert.svh */
// Assertion macros for the code table encoder and packer.
// Used by the top level only; clk_i and rst_ni must be in scope.
`ifndef HUFFMAN_TABLE_ENCODER_PACKER_CORE_ASSERT_SVH
`define HUFFMAN_TABLE_ENCODER_PACKER_CORE_ASSERT_SVH

`ifndef SYNTH
`define HTE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define HTE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define HTE_ASSERT(lbl, prop, msg)
`define HTE_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* hdl/hte_pkg.sv */
// Shared types and constants of the code table encoder and packer.
// No dependencies.
package hte_pkg;

  localparam int unsigned SYMBOL_BITS   = 16;
  localparam int unsigned MAX_CODE_BITS = 32;
  localparam int unsigned WORD_BITS     = 64;
  localparam int unsigned LEN_W         = 6;
  localparam int unsigned BITS_W        = 7;
  localparam int unsigned CFG_W         = 9;
  localparam int unsigned IDX_W         = 8;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_ENCODE = 1'b1;

  localparam logic [LEN_W-1:0] LEN_LIMIT =
      LEN_W'((MAX_CODE_BITS < WORD_BITS) ? MAX_CODE_BITS : WORD_BITS);

  typedef struct packed {
    logic                     cmd;
    logic [IDX_W-1:0]         entry_index;
    logic [SYMBOL_BITS-1:0]   entry_symbol;
    logic [MAX_CODE_BITS-1:0] entry_code;
    logic [LEN_W-1:0]         entry_length;
    logic [SYMBOL_BITS-1:0]   symbol;
    logic                     last_symbol;
  } in_item_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] packed_word;
    logic [BITS_W-1:0]    word_bits;
    logic                 miss;
    logic                 last_out;
  } out_item_t;

  typedef struct packed {
    logic [SYMBOL_BITS-1:0]   symbol;
    logic [MAX_CODE_BITS-1:0] code;
    logic [LEN_W-1:0]         length;
  } entry_t;

  typedef struct packed {
    logic [1:0] n;
    out_item_t  r0;
    out_item_t  r1;
  } pack_res_t;

endpackage

/* hdl/hte_chan_if.sv */
// Valid/ready channel carrying one payload word.
// Payload type is set per instance; no other dependencies.
interface hte_chan_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hdl/hte_table.sv */
// Code table memory: one write port, one read port, registered read data.
// Depends on hte_pkg for the entry type.
module hte_table #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [AW-1:0]   waddr_i,
  input  hte_pkg::entry_t wdata_i,
  input  logic            re_i,
  input  logic [AW-1:0]   raddr_i,
  output hte_pkg::entry_t rdata_o
);

  hte_pkg::entry_t mem [DEPTH];
  hte_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/hte_packer.sv */
// Bit packer: appends one code MSB-first to the pending word, builds results.
// Depends on hte_pkg for entry and result types.
module hte_packer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               pack_en_i,
  input  logic               clear_i,
  input  hte_pkg::entry_t    entry_i,
  input  logic               last_i,
  output hte_pkg::pack_res_t res_o
);

  localparam int unsigned W  = hte_pkg::WORD_BITS;
  localparam int unsigned BW = hte_pkg::BITS_W;
  localparam int unsigned LW = hte_pkg::LEN_W;

  logic [W-1:0]  acc_q, acc_d;
  logic [BW-1:0] bits_q, bits_d;

  logic [W-1:0]  code_w, acc_n, full, part;
  logic [BW-1:0] total, over, bits_n;
  logic [LW-1:0] take;
  logic          ovf;
  hte_pkg::out_item_t full_item, part_item;

  always_comb begin
    code_w = W'(entry_i.code);
    total  = bits_q + BW'(entry_i.length);
    ovf    = (total >= BW'(W));
    over   = total - BW'(W);
    take   = entry_i.length - LW'(over);
    full   = (acc_q << take) | (code_w >> over);
    if (ovf) begin
      acc_n  = code_w & ~({W{1'b1}} << over);
      bits_n = over;
    end else begin
      acc_n  = (acc_q << entry_i.length) | code_w;
      bits_n = total;
    end
    part = (bits_n == '0) ? '0 : (acc_n << (BW'(W) - bits_n));

    full_item.packed_word = full;
    full_item.word_bits   = BW'(W);
    full_item.miss        = 1'b0;
    full_item.last_out    = last_i && (bits_n == '0);

    part_item.packed_word = part;
    part_item.word_bits   = bits_n;
    part_item.miss        = 1'b0;
    part_item.last_out    = 1'b1;

    res_o.r0 = ovf ? full_item : part_item;
    res_o.r1 = part_item;
    priority if (ovf && last_i && (bits_n != '0)) begin
      res_o.n = 2'd2;
    end else if (ovf || last_i) begin
      res_o.n = 2'd1;
    end else begin
      res_o.n = 2'd0;
    end
  end

  always_comb begin
    acc_d  = acc_q;
    bits_d = bits_q;
    if (clear_i || (pack_en_i && last_i)) begin
      acc_d  = '0;
      bits_d = '0;
    end else if (pack_en_i) begin
      acc_d  = acc_n;
      bits_d = bits_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      bits_q <= '0;
    end else begin
      acc_q  <= acc_d;
      bits_q <= bits_d;
    end
  end

endmodule

/* hdl/huffman_table_encoder_packer_core.sv */
// Code table encoder with MSB-first packing into 64-bit words.
// Depends on hte_pkg, hte_chan_if, hte_table, hte_packer and the assert header.
//
// in_if takes load words (cmd 0: write one table entry) and encode words
// (cmd 1: look up one symbol). cfg_if sets the number of entries searched;
// write it only while the block is idle. out_if returns 0, 1 or 2 result
// words per encode word: a full 64-bit word, a partial word on the last
// symbol, or a single miss word that also ends the stream.
// An encode word searches the table from entry 0 up to the match, one table
// read per cycle through the single read port of the table memory, then
// packs the code and emits each result word as the output handshake takes
// it. A miss costs the full search. One encode word is in flight at a time;
// in_if.ready is low from acceptance until the last result word is taken,
// or until the pack step ends when there is none.
// When out_if.ready is low the pending result word holds on the port.
// Reset clears the entry count, the pending word and the control state;
// the table contents are undefined until loaded.
`include "huffman_table_encoder_packer_core_assert.svh"

module huffman_table_encoder_packer_core #(
  parameter int unsigned TABLE_ENTRIES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  hte_chan_if.sink    in_if,
  hte_chan_if.source  out_if,
  hte_chan_if.sink    cfg_if
);

  localparam int unsigned AW     = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CNT_W0 = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned CMP_W  = (CNT_W0 > hte_pkg::CFG_W) ? CNT_W0 : hte_pkg::CFG_W;
  localparam logic [CMP_W-1:0] LIMIT = CMP_W'(TABLE_ENTRIES);
  localparam int unsigned CW     = hte_pkg::MAX_CODE_BITS;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_PACK = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]                   state_q, state_d;
  logic [hte_pkg::CFG_W-1:0]    cfg_q;
  logic [CMP_W-1:0]             count, cfg_w;
  logic [CMP_W-1:0]             scan_addr_q, scan_addr_d;
  logic                         rd_valid_q, rd_valid_d;
  logic                         rd_last_q, rd_last_d;
  logic [hte_pkg::SYMBOL_BITS-1:0] sym_q;
  logic                         last_q;
  hte_pkg::out_item_t           ob_q [2];
  logic                         ob_idx_q, ob_idx_d;
  logic                         ob_two_q, ob_two_d;
  logic                         ob_load_miss, ob_load_pack;

  logic                         in_acc, out_acc, is_encode;
  logic                         tbl_we, tbl_re, hit, miss_now;
  logic [hte_pkg::LEN_W-1:0]    len_sat;
  hte_pkg::entry_t              wentry, rentry;
  hte_pkg::pack_res_t           pres;
  hte_pkg::out_item_t           miss_item;

  // configuration
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_if.valid) begin
      cfg_q <= cfg_if.data;
    end
  end

  assign cfg_w = CMP_W'(cfg_q);
  assign count = (cfg_w > LIMIT) ? LIMIT : cfg_w;

  // table write path
  assign in_if.ready = (state_q == ST_IDLE);
  assign in_acc      = in_if.valid && in_if.ready;
  assign is_encode   = (in_if.data.cmd == hte_pkg::CMD_ENCODE);
  assign tbl_we      = in_acc && (in_if.data.cmd == hte_pkg::CMD_LOAD) &&
                       (CMP_W'(in_if.data.entry_index) < LIMIT);

  always_comb begin
    len_sat = (in_if.data.entry_length > hte_pkg::LEN_LIMIT) ?
              hte_pkg::LEN_LIMIT : in_if.data.entry_length;
    wentry.symbol = in_if.data.entry_symbol;
    wentry.length = len_sat;
    if (len_sat >= hte_pkg::LEN_W'(CW)) begin
      wentry.code = in_if.data.entry_code;
    end else begin
      wentry.code = in_if.data.entry_code & ~({CW{1'b1}} << len_sat);
    end
  end

  // scan
  assign hit    = rd_valid_q && (rentry.symbol == sym_q);
  assign tbl_re = (state_q == ST_SCAN) && (scan_addr_q < count) && !hit;

  hte_table #(
    .DEPTH (TABLE_ENTRIES),
    .AW    (AW)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (AW'(in_if.data.entry_index)),
    .wdata_i (wentry),
    .re_i    (tbl_re),
    .raddr_i (AW'(scan_addr_q)),
    .rdata_o (rentry)
  );

  hte_packer u_packer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .pack_en_i (state_q == ST_PACK),
    .clear_i   (miss_now),
    .entry_i   (rentry),
    .last_i    (last_q),
    .res_o     (pres)
  );

  always_comb begin
    miss_item.packed_word = '0;
    miss_item.word_bits   = '0;
    miss_item.miss        = 1'b1;
    miss_item.last_out    = 1'b1;
  end

  assign out_acc = out_if.valid && out_if.ready;

  always_comb begin
    state_d      = state_q;
    scan_addr_d  = scan_addr_q;
    rd_valid_d   = 1'b0;
    rd_last_d    = 1'b0;
    ob_idx_d     = ob_idx_q;
    ob_two_d     = ob_two_q;
    ob_load_miss = 1'b0;
    ob_load_pack = 1'b0;
    miss_now     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && is_encode) begin
          scan_addr_d = '0;
          if (count == '0) begin
            miss_now     = 1'b1;
            ob_load_miss = 1'b1;
            ob_idx_d     = 1'b0;
            ob_two_d     = 1'b0;
            state_d      = ST_EMIT;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (hit) begin
          state_d = ST_PACK;
        end else if (rd_valid_q && rd_last_q) begin
          miss_now     = 1'b1;
          ob_load_miss = 1'b1;
          ob_idx_d     = 1'b0;
          ob_two_d     = 1'b0;
          state_d      = ST_EMIT;
        end else begin
          rd_valid_d = tbl_re;
          rd_last_d  = tbl_re && ((scan_addr_q + 1'b1) == count);
          if (tbl_re) begin
            scan_addr_d = scan_addr_q + 1'b1;
          end
        end
      end
      ST_PACK: begin
        ob_load_pack = 1'b1;
        ob_idx_d     = 1'b0;
        ob_two_d     = (pres.n == 2'd2);
        state_d      = (pres.n == 2'd0) ? ST_IDLE : ST_EMIT;
      end
      ST_EMIT: begin
        if (out_acc) begin
          if (ob_idx_q == ob_two_q) begin
            state_d = ST_IDLE;
          end else begin
            ob_idx_d = 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      scan_addr_q <= '0;
      rd_valid_q  <= 1'b0;
      rd_last_q   <= 1'b0;
      ob_idx_q    <= 1'b0;
      ob_two_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      scan_addr_q <= scan_addr_d;
      rd_valid_q  <= rd_valid_d;
      rd_last_q   <= rd_last_d;
      ob_idx_q    <= ob_idx_d;
      ob_two_q    <= ob_two_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && is_encode) begin
      sym_q  <= in_if.data.symbol;
      last_q <= in_if.data.last_symbol;
    end
    if (ob_load_miss) begin
      ob_q[0] <= miss_item;
    end else if (ob_load_pack) begin
      ob_q[0] <= pres.r0;
      ob_q[1] <= pres.r1;
    end
  end

  assign out_if.valid = (state_q == ST_EMIT);
  assign out_if.data  = ob_q[ob_idx_q];

  `HTE_ASSERT(a_no_load_when_busy, (state_q != ST_IDLE) |-> !tbl_we, "table written while busy")
  `HTE_ASSERT(a_pack_after_scan, (state_q == ST_PACK) |-> ($past(state_q) == ST_SCAN && $past(hit)), "pack without a table hit")
  `HTE_ASSERT(a_read_only_in_scan, rd_valid_q |-> (state_q == ST_SCAN), "read data pending outside scan")
  `HTE_ASSERT_ALWAYS(a_miss_ends_stream, (out_if.valid && out_if.data.miss) |-> (out_if.data.last_out && out_if.data.word_bits == '0), "miss word not final")

endmodule
